FILE: rtl/core/srmp_pkg.sv
// Shared types, constants and the microcode table of the step ramp generator.
// No dependencies; the top level, divider and bench refer to it by scoped names.
`timescale 1ns / 1ps

package srmp_pkg;

   localparam int COUNT_WIDTH  = 32;
   localparam int PERIOD_WIDTH = 16;
   localparam int CMP_WIDTH    = (COUNT_WIDTH > PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(PERIOD_WIDTH);
   localparam int UADDR_WIDTH  = 4;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CMP_WIDTH-1:0] COUNT_MAX = CMP_WIDTH'({COUNT_WIDTH{1'b1}});

   localparam logic [PERIOD_WIDTH-1:0] START_PERIOD_RESET = 16'd64000;
   localparam logic [PERIOD_WIDTH-1:0] MIN_PERIOD_RESET   = 16'd16000;
   localparam logic [PERIOD_WIDTH-1:0] RAMP_STEP_RESET    = 16'd100;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_ACCEL  = 3'd1,
      PH_STEADY = 3'd2,
      PH_DECEL  = 3'd3,
      PH_STOP   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_START     = 2'd1,
      CMD_SOFT_STOP = 2'd2,
      CMD_HARD_STOP = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_PERIOD = 2'd0,
      CSR_MIN_PERIOD   = 2'd1,
      CSR_RAMP_STEP    = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_LATCH,
      UOP_TICK_COUNT,
      UOP_DIV_INIT,
      UOP_DIV_STEP,
      UOP_STEADY_CMP,
      UOP_TICK_PHASE,
      UOP_START,
      UOP_SOFT_LOAD,
      UOP_HARD,
      UOP_EMIT
   } uop_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_REQ_XFER,
      COND_CMD,
      COND_DIV_BUSY,
      COND_NOT_STEADY,
      COND_RSP_FREE
   } cond_type;

   typedef struct packed {
      uop_type                uop;
      cond_type               cond;
      logic                   hold;
      logic [UADDR_WIDTH-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic init;
      logic step;
   } div_ctrl_type;

   localparam logic [UADDR_WIDTH-1:0] ADDR_WAIT       = 4'd0;
   localparam logic [UADDR_WIDTH-1:0] ADDR_DISPATCH   = 4'd1;
   localparam logic [UADDR_WIDTH-1:0] ADDR_TICK       = 4'd2;
   localparam logic [UADDR_WIDTH-1:0] ADDR_TICK_DIV   = 4'd3;
   localparam logic [UADDR_WIDTH-1:0] ADDR_TICK_LOOP  = 4'd4;
   localparam logic [UADDR_WIDTH-1:0] ADDR_TICK_CMP   = 4'd5;
   localparam logic [UADDR_WIDTH-1:0] ADDR_TICK_PHASE = 4'd6;
   localparam logic [UADDR_WIDTH-1:0] ADDR_START      = 4'd7;
   localparam logic [UADDR_WIDTH-1:0] ADDR_SOFT       = 4'd8;
   localparam logic [UADDR_WIDTH-1:0] ADDR_SOFT_LOOP  = 4'd9;
   localparam logic [UADDR_WIDTH-1:0] ADDR_SOFT_LOAD  = 4'd10;
   localparam logic [UADDR_WIDTH-1:0] ADDR_EMIT       = 4'd11;
   localparam logic [UADDR_WIDTH-1:0] ADDR_HARD       = 4'd12;

   function automatic ucode_type ucode_rom(input logic [UADDR_WIDTH-1:0] addr);
      ucode_type word;
      word = '{uop: UOP_NOP, cond: COND_ALWAYS, hold: 1'b0, target: ADDR_WAIT};
      case (addr)
         ADDR_WAIT:       word = '{UOP_LATCH,      COND_REQ_XFER,   1'b1, ADDR_DISPATCH};
         ADDR_DISPATCH:   word = '{UOP_NOP,        COND_CMD,        1'b0, ADDR_WAIT};
         ADDR_TICK:       word = '{UOP_TICK_COUNT, COND_NONE,       1'b0, ADDR_WAIT};
         ADDR_TICK_DIV:   word = '{UOP_DIV_INIT,   COND_NOT_STEADY, 1'b0, ADDR_TICK_PHASE};
         ADDR_TICK_LOOP:  word = '{UOP_DIV_STEP,   COND_DIV_BUSY,   1'b0, ADDR_TICK_LOOP};
         ADDR_TICK_CMP:   word = '{UOP_STEADY_CMP, COND_ALWAYS,     1'b0, ADDR_EMIT};
         ADDR_TICK_PHASE: word = '{UOP_TICK_PHASE, COND_ALWAYS,     1'b0, ADDR_EMIT};
         ADDR_START:      word = '{UOP_START,      COND_ALWAYS,     1'b0, ADDR_EMIT};
         ADDR_SOFT:       word = '{UOP_DIV_INIT,   COND_NONE,       1'b0, ADDR_WAIT};
         ADDR_SOFT_LOOP:  word = '{UOP_DIV_STEP,   COND_DIV_BUSY,   1'b0, ADDR_SOFT_LOOP};
         ADDR_SOFT_LOAD:  word = '{UOP_SOFT_LOAD,  COND_NONE,       1'b0, ADDR_WAIT};
         ADDR_EMIT:       word = '{UOP_EMIT,       COND_RSP_FREE,   1'b1, ADDR_WAIT};
         ADDR_HARD:       word = '{UOP_HARD,       COND_ALWAYS,     1'b0, ADDR_EMIT};
         default:         word = '{UOP_NOP,        COND_ALWAYS,     1'b0, ADDR_WAIT};
      endcase
      return word;
   endfunction

   function automatic logic [UADDR_WIDTH-1:0] cmd_target(input cmd_type cmd);
      logic [UADDR_WIDTH-1:0] addr;
      case (cmd)
         CMD_TICK:      addr = ADDR_TICK;
         CMD_START:     addr = ADDR_START;
         CMD_SOFT_STOP: addr = ADDR_SOFT;
         CMD_HARD_STOP: addr = ADDR_HARD;
         default:       addr = ADDR_WAIT;
      endcase
      return addr;
   endfunction

endpackage

FILE: rtl/core/srmp_req_if.sv
// Command channel: valid/ready handshake with command code and step count.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface srmp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] step_count;

   modport source (output valid, output cmd, output step_count, input ready);
   modport sink   (input valid, input cmd, input step_count, output ready);
endinterface

FILE: rtl/core/srmp_rsp_if.sv
// Result channel: valid/ready handshake with period, enable, phase and steps left.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface srmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] period;
   logic        output_enable;
   logic [2:0]  phase;
   logic [31:0] steps_left;

   modport source (output valid, output period, output output_enable, output phase,
                   output steps_left, input ready);
   modport sink   (input valid, input period, input output_enable, input phase,
                   input steps_left, output ready);
endinterface

FILE: rtl/core/stepper_trapezoid_ramp.sv
// Trapezoidal step-period ramp generator, top level.
// Depends on srmp_pkg, srmp_req_if, srmp_rsp_if and srmp_divider.
`timescale 1ns / 1ps

// One command is taken at a time. A start move or hard stop runs from dispatch through its
// own step to the emit step; a tick outside the steady phase runs the count, divider set-up
// and phase steps. A soft stop and a tick in the steady phase also wait on the deceleration
// distance, which comes from a restoring divider stepped by the microcode sequencer. The
// result sits in an output register, so the next command is taken while it waits;
// a following result waits for that register to drain. Configuration writes
// through the csr_ port take effect at once and are meant for idle periods.
module stepper_trapezoid_ramp (
   input  logic                                 clock,
   input  logic                                 reset,
   srmp_req_if.sink                             req_ch,
   srmp_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [srmp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [srmp_pkg::PERIOD_WIDTH-1:0]    csr_wdata
);

   logic [srmp_pkg::PERIOD_WIDTH-1:0] start_period_ff, min_period_ff, ramp_step_ff;

   logic [srmp_pkg::UADDR_WIDTH-1:0]  upc_ff, upc_in;
   srmp_pkg::ucode_type               word;
   logic                              taken;

   logic [1:0]                        cmd_ff;
   logic [31:0]                       count_ff;

   logic [srmp_pkg::COUNT_WIDTH-1:0]  steps_ff, steps_in;
   logic [srmp_pkg::PERIOD_WIDTH-1:0] period_ff, period_in;
   srmp_pkg::phase_type               phase_ff, phase_in;
   logic                              pulse_ff, pulse_in;

   logic                              rsp_valid_ff;
   logic [srmp_pkg::PERIOD_WIDTH-1:0] rsp_period_ff;
   logic                              rsp_enable_ff;
   logic [2:0]                        rsp_phase_ff;
   logic [31:0]                       rsp_steps_ff;

   logic                              req_xfer;
   logic                              rsp_free;
   logic                              emit;

   srmp_pkg::div_ctrl_type            div_ctrl;
   logic [srmp_pkg::PERIOD_WIDTH-1:0] quotient;
   logic                              div_last;
   logic [srmp_pkg::CMP_WIDTH-1:0]    quot_ext;
   logic [srmp_pkg::CMP_WIDTH-1:0]    steps_ext;
   logic [srmp_pkg::PERIOD_WIDTH:0]   accel_limit;
   logic [srmp_pkg::PERIOD_WIDTH:0]   decel_sum;

   srmp_divider u_divider (
      .clock          (clock),
      .ctrl           (div_ctrl),
      .start_period   (start_period_ff),
      .current_period (period_ff),
      .ramp_step      (ramp_step_ff),
      .quotient       (quotient),
      .last           (div_last)
   );

   assign word     = srmp_pkg::ucode_rom(upc_ff);
   assign req_ch.ready = (word.uop == srmp_pkg::UOP_LATCH) && !reset;
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit     = (word.uop == srmp_pkg::UOP_EMIT) && rsp_free;

   // sequencer: next microcode address
   always_comb begin
      case (word.cond)
         srmp_pkg::COND_NONE:       taken = 1'b0;
         srmp_pkg::COND_ALWAYS:     taken = 1'b1;
         srmp_pkg::COND_REQ_XFER:   taken = req_xfer;
         srmp_pkg::COND_CMD:        taken = 1'b1;
         srmp_pkg::COND_DIV_BUSY:   taken = !div_last;
         srmp_pkg::COND_NOT_STEADY: taken = (phase_ff != srmp_pkg::PH_STEADY);
         srmp_pkg::COND_RSP_FREE:   taken = rsp_free;
         default:                   taken = 1'b0;
      endcase
      if (word.cond == srmp_pkg::COND_CMD) begin
         upc_in = srmp_pkg::cmd_target(srmp_pkg::cmd_type'(cmd_ff));
      end else if (taken) begin
         upc_in = word.target;
      end else if (word.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = upc_ff + srmp_pkg::UADDR_WIDTH'(1);
      end
   end

   // datapath control from the current control word
   always_comb begin
      quot_ext    = srmp_pkg::CMP_WIDTH'(quotient);
      steps_ext   = srmp_pkg::CMP_WIDTH'(steps_ff);
      accel_limit = {1'b0, min_period_ff} + {1'b0, ramp_step_ff};
      decel_sum   = {1'b0, period_ff} + {1'b0, ramp_step_ff};
      steps_in    = steps_ff;
      period_in   = period_ff;
      phase_in    = phase_ff;
      pulse_in    = pulse_ff;
      div_ctrl    = '{init: 1'b0, step: 1'b0};
      case (word.uop)
         srmp_pkg::UOP_TICK_COUNT: begin
            if (steps_ff <= srmp_pkg::COUNT_WIDTH'(1)) begin
               steps_in = '0;
               phase_in = srmp_pkg::PH_STOP;
            end else begin
               steps_in = steps_ff - srmp_pkg::COUNT_WIDTH'(1);
            end
         end
         srmp_pkg::UOP_DIV_INIT: div_ctrl.init = 1'b1;
         srmp_pkg::UOP_DIV_STEP: div_ctrl.step = 1'b1;
         srmp_pkg::UOP_STEADY_CMP: begin
            if (steps_ext <= quot_ext) begin
               phase_in = srmp_pkg::PH_DECEL;
            end
         end
         srmp_pkg::UOP_TICK_PHASE: begin
            case (phase_ff)
               srmp_pkg::PH_ACCEL: begin
                  if ({1'b0, period_ff} <= accel_limit) begin
                     period_in = min_period_ff;
                     phase_in  = srmp_pkg::PH_STEADY;
                  end else begin
                     period_in = period_ff - ramp_step_ff;
                  end
                  pulse_in = 1'b1;
               end
               srmp_pkg::PH_DECEL: begin
                  if (decel_sum >= {1'b0, start_period_ff}) begin
                     period_in = start_period_ff;
                     phase_in  = srmp_pkg::PH_STOP;
                  end else begin
                     period_in = decel_sum[srmp_pkg::PERIOD_WIDTH-1:0];
                  end
                  pulse_in = 1'b1;
               end
               srmp_pkg::PH_STOP: pulse_in = 1'b0;
               default: ;
            endcase
         end
         srmp_pkg::UOP_START: begin
            steps_in  = count_ff[srmp_pkg::COUNT_WIDTH-1:0];
            period_in = start_period_ff;
            phase_in  = srmp_pkg::PH_ACCEL;
            pulse_in  = 1'b1;
         end
         srmp_pkg::UOP_SOFT_LOAD: begin
            if (quot_ext > srmp_pkg::COUNT_MAX) begin
               steps_in = srmp_pkg::COUNT_MAX[srmp_pkg::COUNT_WIDTH-1:0];
            end else begin
               steps_in = quot_ext[srmp_pkg::COUNT_WIDTH-1:0];
            end
         end
         srmp_pkg::UOP_HARD: pulse_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff          <= srmp_pkg::ADDR_WAIT;
         steps_ff        <= '0;
         period_ff       <= srmp_pkg::START_PERIOD_RESET;
         phase_ff        <= srmp_pkg::PH_IDLE;
         pulse_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         start_period_ff <= srmp_pkg::START_PERIOD_RESET;
         min_period_ff   <= srmp_pkg::MIN_PERIOD_RESET;
         ramp_step_ff    <= srmp_pkg::RAMP_STEP_RESET;
      end else begin
         upc_ff    <= upc_in;
         steps_ff  <= steps_in;
         period_ff <= period_in;
         phase_ff  <= phase_in;
         pulse_ff  <= pulse_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (srmp_pkg::csr_index_type'(csr_index))
               srmp_pkg::CSR_START_PERIOD: start_period_ff <= csr_wdata;
               srmp_pkg::CSR_MIN_PERIOD:   min_period_ff   <= csr_wdata;
               srmp_pkg::CSR_RAMP_STEP:    ramp_step_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // hold command and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff   <= req_ch.cmd;
         count_ff <= req_ch.step_count;
      end
      if (emit) begin
         rsp_period_ff <= period_ff;
         rsp_enable_ff <= pulse_ff;
         rsp_phase_ff  <= phase_ff;
         rsp_steps_ff  <= 32'(steps_ff);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.period        = rsp_period_ff;
   assign rsp_ch.output_enable = rsp_enable_ff;
   assign rsp_ch.phase         = rsp_phase_ff;
   assign rsp_ch.steps_left    = rsp_steps_ff;

   a_xfer_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (upc_ff == srmp_pkg::ADDR_DISPATCH))
      else $error("command transfer not followed by dispatch");

   a_hard_stop_off: assert property (@(posedge clock) disable iff (reset)
      (word.uop == srmp_pkg::UOP_HARD) |=> !pulse_ff)
      else $error("pulse output still on after hard stop");

   a_idle_off: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == srmp_pkg::PH_IDLE) |-> !pulse_ff)
      else $error("pulse output on while idle");

   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(upc_ff) == srmp_pkg::ADDR_EMIT))
      else $error("result raised outside the emit step");

endmodule

FILE: rtl/core/srmp_divider.sv
// Restoring divider, one quotient bit per cycle while stepped: (start - current) / ramp_step.
// Depends on srmp_pkg for widths and the control struct.
`timescale 1ns / 1ps

module srmp_divider (
   input  logic                              clock,
   input  srmp_pkg::div_ctrl_type            ctrl,
   input  logic [srmp_pkg::PERIOD_WIDTH-1:0] start_period,
   input  logic [srmp_pkg::PERIOD_WIDTH-1:0] current_period,
   input  logic [srmp_pkg::PERIOD_WIDTH-1:0] ramp_step,
   output logic [srmp_pkg::PERIOD_WIDTH-1:0] quotient,
   output logic                              last
);

   logic [srmp_pkg::PERIOD_WIDTH-1:0]  num_ff, num_in;
   logic [srmp_pkg::PERIOD_WIDTH-1:0]  den_ff, den_in;
   logic [srmp_pkg::PERIOD_WIDTH-1:0]  rem_ff, rem_in;
   logic [srmp_pkg::DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [srmp_pkg::PERIOD_WIDTH:0]    trial;
   logic [srmp_pkg::PERIOD_WIDTH:0]    diff;
   logic                               fits;

   always_comb begin
      trial  = {rem_ff, num_ff[srmp_pkg::PERIOD_WIDTH-1]};
      diff   = trial - {1'b0, den_ff};
      fits   = (trial >= {1'b0, den_ff});
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (ctrl.init) begin
         // zero divisor or no headroom: zero numerator, nonzero divisor gives zero
         if (ramp_step == '0 || current_period >= start_period) begin
            num_in = '0;
         end else begin
            num_in = start_period - current_period;
         end
         den_in = (ramp_step == '0) ? srmp_pkg::PERIOD_WIDTH'(1) : ramp_step;
         rem_in = '0;
         cnt_in = srmp_pkg::DIV_CNT_WIDTH'(srmp_pkg::PERIOD_WIDTH - 1);
      end else if (ctrl.step) begin
         rem_in = fits ? diff[srmp_pkg::PERIOD_WIDTH-1:0] : trial[srmp_pkg::PERIOD_WIDTH-1:0];
         num_in = {num_ff[srmp_pkg::PERIOD_WIDTH-2:0], fits};
         cnt_in = cnt_ff - srmp_pkg::DIV_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = num_ff;
   assign last     = (cnt_ff == '0);

endmodule

FILE: sim/stepper_trapezoid_ramp_tb.sv
// Self-checking bench for the trapezoidal step-period ramp generator.
// Depends on srmp_pkg, srmp_req_if, srmp_rsp_if and stepper_trapezoid_ramp.
`timescale 1ns / 1ps

module stepper_trapezoid_ramp_tb;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 50;

   typedef struct packed {
      logic [15:0]         period;
      logic                output_enable;
      srmp_pkg::phase_type phase;
      logic [31:0]         steps_left;
   } ramp_result_type;

   class ramp_scoreboard;
      logic [15:0]         start_period;
      logic [15:0]         min_period;
      logic [15:0]         ramp_step;
      logic [31:0]         steps_remaining;
      logic [15:0]         current_period;
      srmp_pkg::phase_type ramp_phase;
      logic                pulse_on;
      ramp_result_type     expected_q[$];
      int                  errors;

      function new();
         start_period    = srmp_pkg::START_PERIOD_RESET;
         min_period      = srmp_pkg::MIN_PERIOD_RESET;
         ramp_step       = srmp_pkg::RAMP_STEP_RESET;
         steps_remaining = '0;
         current_period  = srmp_pkg::START_PERIOD_RESET;
         ramp_phase      = srmp_pkg::PH_IDLE;
         pulse_on        = 1'b0;
         errors          = 0;
      endfunction

      function void write_reg(srmp_pkg::csr_index_type idx, logic [15:0] value);
         case (idx)
            srmp_pkg::CSR_START_PERIOD: start_period = value;
            srmp_pkg::CSR_MIN_PERIOD:   min_period   = value;
            srmp_pkg::CSR_RAMP_STEP:    ramp_step    = value;
            default: ;
         endcase
      endfunction

      function logic [31:0] decel_distance();
         if (ramp_step == 16'd0 || current_period >= start_period)
            return 32'd0;
         return 32'((start_period - current_period) / ramp_step);
      endfunction

      function void advance_tick();
         int p;
         if (steps_remaining <= 32'd1) begin
            steps_remaining = 32'd0;
            ramp_phase      = srmp_pkg::PH_STOP;
         end else begin
            steps_remaining = steps_remaining - 32'd1;
         end
         case (ramp_phase)
            srmp_pkg::PH_ACCEL: begin
               p = int'(current_period) - int'(ramp_step);
               if (p <= int'(min_period)) begin
                  current_period = min_period;
                  ramp_phase     = srmp_pkg::PH_STEADY;
               end else begin
                  current_period = 16'(p);
               end
               pulse_on = 1'b1;
            end
            srmp_pkg::PH_STEADY: begin
               if (steps_remaining <= decel_distance())
                  ramp_phase = srmp_pkg::PH_DECEL;
            end
            srmp_pkg::PH_DECEL: begin
               p = int'(current_period) + int'(ramp_step);
               if (p >= int'(start_period)) begin
                  current_period = start_period;
                  ramp_phase     = srmp_pkg::PH_STOP;
               end else begin
                  current_period = 16'(p);
               end
               pulse_on = 1'b1;
            end
            srmp_pkg::PH_STOP: pulse_on = 1'b0;
            default: ;
         endcase
      endfunction

      function void note_cmd(srmp_pkg::cmd_type cmd, logic [31:0] count);
         ramp_result_type res;
         case (cmd)
            srmp_pkg::CMD_TICK: advance_tick();
            srmp_pkg::CMD_START: begin
               steps_remaining = count;
               current_period  = start_period;
               ramp_phase      = srmp_pkg::PH_ACCEL;
               pulse_on        = 1'b1;
            end
            srmp_pkg::CMD_SOFT_STOP: steps_remaining = decel_distance();
            default: pulse_on = 1'b0;
         endcase
         res.period        = current_period;
         res.output_enable = pulse_on;
         res.phase         = ramp_phase;
         res.steps_left    = steps_remaining;
         expected_q.push_back(res);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string msg);
         $display("[%0t] result error: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(ramp_result_type got);
         ramp_result_type exp_res;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result period=%0d oe=%0b phase=%0d steps=%0d",
                             got.period, got.output_enable, got.phase, got.steps_left));
         end else begin
            exp_res = expected_q.pop_front();
            if (got.period != exp_res.period || got.output_enable != exp_res.output_enable ||
                got.phase != exp_res.phase || got.steps_left != exp_res.steps_left)
               report($sformatf("got period=%0d oe=%0b phase=%0d steps=%0d, want %0d %0b %0d %0d",
                                got.period, got.output_enable, got.phase, got.steps_left,
                                exp_res.period, exp_res.output_enable, exp_res.phase,
                                exp_res.steps_left));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [srmp_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [srmp_pkg::PERIOD_WIDTH-1:0]    csr_wdata;

   int send_idle;
   int recv_stall;
   int quiet_cycles;

   ramp_scoreboard sb;

   srmp_req_if req_bus ();
   srmp_rsp_if rsp_bus ();

   stepper_trapezoid_ramp DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(0, 99) >= recv_stall);
      end
   end

   // Check every transfer and watch for a stalled run.
   always @(posedge clock) begin
      ramp_result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_cmd(srmp_pkg::cmd_type'(req_bus.cmd), req_bus.step_count);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.period        = rsp_bus.period;
            got.output_enable = rsp_bus.output_enable;
            got.phase         = srmp_pkg::phase_type'(rsp_bus.phase);
            got.steps_left    = rsp_bus.steps_left;
            sb.check_result(got);
         end
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("stepper_trapezoid_ramp: mismatch");
         $finish;
      end
   end

   task automatic send_cmd(input srmp_pkg::cmd_type cmd, input logic [31:0] count);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.cmd        = cmd;
      req_bus.step_count = count;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input srmp_pkg::csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_ramp(input logic [15:0] sp, input logic [15:0] mp,
                             input logic [15:0] rs);
      write_csr(srmp_pkg::CSR_START_PERIOD, sp);
      write_csr(srmp_pkg::CSR_MIN_PERIOD, mp);
      write_csr(srmp_pkg::CSR_RAMP_STEP, rs);
   endtask

   initial begin
      logic [15:0]       sp;
      logic [15:0]       mp;
      logic [15:0]       rs;
      logic [31:0]       cnt;
      srmp_pkg::cmd_type c;
      int                n;
      int                len;
      int                r;

      sb                 = new();
      quiet_cycles       = 0;
      send_idle          = 0;
      recv_stall         = 0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = '0;
      req_bus.step_count = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: tick and stops from idle, full and tiny moves, stops mid-move.
      send_cmd(srmp_pkg::CMD_TICK, 32'h0);
      send_cmd(srmp_pkg::CMD_SOFT_STOP, 32'h0);
      send_cmd(srmp_pkg::CMD_HARD_STOP, 32'hFFFF_FFFF);
      send_cmd(srmp_pkg::CMD_START, 32'hFFFF_FFFF);
      repeat (3) send_cmd(srmp_pkg::CMD_TICK, 32'h0);
      send_cmd(srmp_pkg::CMD_SOFT_STOP, 32'h0);
      repeat (3) send_cmd(srmp_pkg::CMD_TICK, 32'h0);
      send_cmd(srmp_pkg::CMD_START, 32'd1);
      send_cmd(srmp_pkg::CMD_TICK, 32'h0);
      send_cmd(srmp_pkg::CMD_START, 32'd0);
      send_cmd(srmp_pkg::CMD_HARD_STOP, 32'h0);
      send_cmd(srmp_pkg::CMD_TICK, 32'h0);

      // Zero ramp step, minimum equal to start.
      wait_drained();
      write_ramp(16'hFFFF, 16'hFFFF, 16'h0000);
      write_csr(srmp_pkg::CSR_UNUSED, 16'hFFFF);
      send_cmd(srmp_pkg::CMD_START, 32'd5);
      repeat (2) send_cmd(srmp_pkg::CMD_TICK, 32'h0);
      send_cmd(srmp_pkg::CMD_SOFT_STOP, 32'h0);
      send_cmd(srmp_pkg::CMD_TICK, 32'h0);

      // Ramp step overshoots below zero.
      wait_drained();
      write_ramp(16'd1, 16'd1, 16'hFFFF);
      send_cmd(srmp_pkg::CMD_START, 32'd2);
      repeat (2) send_cmd(srmp_pkg::CMD_TICK, 32'h0);

      for (int seg = 0; seg < 8; seg++) begin
         wait_drained();
         case (seg)
            0: begin
               sp = 16'($urandom_range(2000, 65535));
               mp = 16'($urandom_range(1, sp));
               rs = 16'((sp - mp) / $urandom_range(1, 20));
            end
            1: begin
               sp = 16'hFFFF;
               mp = 16'd1;
               rs = 16'hFFFF;
            end
            2: begin
               sp = 16'hFFFF;
               mp = 16'd1;
               rs = 16'($urandom_range(2000, 8000));
            end
            3: begin
               sp = 16'd1;
               mp = 16'hFFFF;
               rs = 16'd0;
            end
            default: begin
               sp = 16'($urandom_range(1, 65535));
               mp = 16'($urandom_range(1, 65535));
               if ($urandom_range(0, 3) == 0 || sp <= mp)
                  rs = 16'($urandom_range(0, 65535));
               else
                  rs = 16'((sp - mp) / $urandom_range(1, 20));
            end
         endcase
         write_ramp(sp, mp, rs);
         case (seg % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 81; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 81; end
            default: begin send_idle = 31; recv_stall = 31; end
         endcase
         n = 0;
         while (n < 100) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               cnt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
               send_cmd(srmp_pkg::CMD_START, cnt);
               n++;
               len = $urandom_range(0, 45);
               for (int i = 0; i < len; i++) begin
                  r = $urandom_range(0, 99);
                  if (r < 6)
                     c = srmp_pkg::CMD_SOFT_STOP;
                  else if (r < 10)
                     c = srmp_pkg::CMD_HARD_STOP;
                  else
                     c = srmp_pkg::CMD_TICK;
                  send_cmd(c, $urandom);
                  n++;
               end
            end else begin
               send_cmd(srmp_pkg::cmd_type'($urandom_range(0, 3)), $urandom);
               n++;
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("stepper_trapezoid_ramp: match");
      else
         $display("stepper_trapezoid_ramp: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/srmp_pkg.sv
rtl/core/srmp_req_if.sv
rtl/core/srmp_rsp_if.sv
rtl/core/srmp_divider.sv
rtl/core/stepper_trapezoid_ramp.sv
sim/stepper_trapezoid_ramp_tb.sv
